// ===== sv/whs_pkg.sv =====
package whs_pkg;

  localparam int MAX_NEIGHBOURS = 16;
  localparam int RATE_BITS      = 32;

  // Widths fixed by the transaction fields.
  localparam int SLOT_BITS   = 4;
  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 32;
  localparam int SUM_BITS    = 36;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;
  localparam int HI_BITS     = SUM_BITS - FRAC_BITS;

  localparam int IDX_BITS = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int CNT_BITS = $clog2(MAX_NEIGHBOURS + 1);
  localparam int CUM_RAW  = RATE_BITS + CNT_BITS;
  localparam int CUM_BITS = (CUM_RAW > SUM_BITS) ? CUM_RAW : SUM_BITS;

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [0:0] REG_NEIGHBOUR_COUNT = 1'b0;

  localparam logic [1:0] REQ_WRITE_RATE   = 2'd0;
  localparam logic [1:0] REQ_SET_OCC      = 2'd1;
  localparam logic [1:0] REQ_CHOOSE_ANY   = 2'd2;
  localparam logic [1:0] REQ_CHOOSE_FREE  = 2'd3;

  localparam logic [STATUS_BITS-1:0] STATUS_CHOSEN = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NONE   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_DONE   = 2'd2;

  typedef enum logic [1:0] {
    OP_RATE,
    OP_OCC,
    OP_ANY,
    OP_FREE
  } op_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SUM,
    BS_MUL,
    BS_ADD,
    BS_WALK
  } bstate_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] rate_value;
    logic                  occupied_flag;
    logic [FRAC_BITS-1:0]  random_fraction;
  } whs_in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   chosen_slot;
    logic [SUM_BITS-1:0]    total_rate;
  } whs_out_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    op_t                  op;
    logic                 slot_ok;
    logic [IDX_BITS-1:0]  slot;
    logic [RATE_BITS-1:0] rate;
    logic                 occ;
    logic [FRAC_BITS-1:0] frac;
  } whs_item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } whs_qstat_t;

endpackage

// ===== sv/whs_front.sv =====
module whs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  whs_pkg::whs_in_t  in_data,
  input  whs_pkg::whs_qstat_t q_stat,
  output logic              q_push,
  output whs_pkg::whs_item_t q_item
);
  import whs_pkg::*;

  logic      hold_valid_r, hold_valid_nxt;
  whs_item_t hold_item_r;
  whs_item_t dec_item;
  logic      accept;

  assign busy   = hold_valid_r && q_stat.full;
  assign accept = start && !busy;
  assign q_push = hold_valid_r && !q_stat.full;
  assign q_item = hold_item_r;

  always_comb begin
    dec_item         = '0;
    dec_item.slot_ok = (int'(in_data.slot) < MAX_NEIGHBOURS);
    dec_item.slot    = IDX_BITS'(in_data.slot);
    dec_item.rate    = RATE_BITS'(in_data.rate_value);
    dec_item.occ     = in_data.occupied_flag;
    dec_item.frac    = in_data.random_fraction;
    unique case (in_data.req_type)
      REQ_WRITE_RATE:  dec_item.op = OP_RATE;
      REQ_SET_OCC:     dec_item.op = OP_OCC;
      REQ_CHOOSE_ANY:  dec_item.op = OP_ANY;
      REQ_CHOOSE_FREE: dec_item.op = OP_FREE;
      default:         dec_item.op = OP_RATE;
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item_r <= dec_item;
    end
  end

endmodule

// ===== sv/whs_queue.sv =====
module whs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  whs_pkg::whs_item_t  push_item,
  input  logic                pop,
  output whs_pkg::whs_item_t  head,
  output whs_pkg::whs_qstat_t stat
);
  import whs_pkg::*;

  whs_item_t             entry_r [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  count_r, count_nxt;

  assign head           = entry_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == QCNT_BITS'(QDEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/whs_back.sv =====
module whs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [whs_pkg::COUNT_BITS-1:0] neighbour_count,
  input  whs_pkg::whs_item_t             q_head,
  input  whs_pkg::whs_qstat_t            q_stat,
  output logic                           q_pop,
  output logic                           out_valid,
  output whs_pkg::whs_out_t              out_data
);
  import whs_pkg::*;

  bstate_t state_r, state_nxt;

  logic [RATE_BITS-1:0]        rate_tbl_r [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS-1:0]   occ_r;
  logic [SUM_BITS-1:0]         rate_sum_r, rate_sum_nxt;
  logic                        out_valid_r, out_valid_nxt;
  whs_out_t                    out_data_r, out_data_nxt;

  logic                        free_r;
  logic [FRAC_BITS-1:0]        frac_r;
  logic [SUM_BITS-1:0]         total_r, total_nxt;
  logic [2*FRAC_BITS-1:0]      plo_r;
  logic [FRAC_BITS+HI_BITS-1:0] phi_r;
  logic [SUM_BITS-1:0]         target_r;
  logic [CUM_BITS-1:0]         cum_r, cum_nxt;
  logic [CNT_BITS-1:0]         idx_r, idx_nxt;

  logic [CNT_BITS-1:0]         walk_len;
  logic [IDX_BITS-1:0]         rd_idx;
  logic [RATE_BITS-1:0]        rd_rate;
  logic                        rd_occ;
  logic                        walk_done;
  logic                        eligible;
  logic [CUM_BITS-1:0]         cum_add;
  logic                        hit;
  logic                        tbl_we;
  logic                        occ_we;
  logic                        is_update;

  assign walk_len = (int'(neighbour_count) > MAX_NEIGHBOURS) ?
                    CNT_BITS'(MAX_NEIGHBOURS) : CNT_BITS'(neighbour_count);

  // A single read port on the table: the queue head slot while idle,
  // otherwise the walk position.
  assign rd_idx  = (state_r == BS_IDLE) ? q_head.slot : idx_r[IDX_BITS-1:0];
  assign rd_rate = rate_tbl_r[rd_idx];
  assign rd_occ  = occ_r[rd_idx];

  // Past the end of the walk the read index wraps, so a hit is only valid
  // while the position is still inside the walked range.
  assign walk_done = (idx_r == walk_len);
  assign eligible  = !(free_r && rd_occ);
  assign cum_add   = cum_r + (eligible ? CUM_BITS'(rd_rate) : '0);
  assign hit       = eligible && !walk_done && (cum_add >= CUM_BITS'(target_r));
  assign is_update = (q_head.op == OP_RATE) || (q_head.op == OP_OCC);

  assign q_pop     = (state_r == BS_IDLE) && q_stat.not_empty;
  assign tbl_we    = q_pop && (q_head.op == OP_RATE) && q_head.slot_ok;
  assign occ_we    = q_pop && (q_head.op == OP_OCC) && q_head.slot_ok;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (q_stat.not_empty) begin
          unique case (q_head.op)
            OP_ANY:  state_nxt = BS_MUL;
            OP_FREE: state_nxt = BS_SUM;
            default: state_nxt = BS_IDLE;
          endcase
        end
      end
      BS_SUM:  state_nxt = walk_done ? BS_MUL : BS_SUM;
      BS_MUL:  state_nxt = BS_ADD;
      BS_ADD:  state_nxt = BS_WALK;
      BS_WALK: state_nxt = (walk_done || hit) ? BS_IDLE : BS_WALK;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    rate_sum_nxt  = rate_sum_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    idx_nxt       = idx_r;
    unique case (state_r)
      BS_IDLE: begin
        idx_nxt   = '0;
        cum_nxt   = '0;
        total_nxt = rate_sum_r;
        if (tbl_we) begin
          rate_sum_nxt = SUM_BITS'(rate_sum_r - SUM_BITS'(rd_rate) + SUM_BITS'(q_head.rate));
        end
        if (q_pop && is_update) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = STATUS_DONE;
          out_data_nxt.chosen_slot = '0;
          out_data_nxt.total_rate  = rate_sum_nxt;
        end
      end
      BS_SUM: begin
        if (walk_done) begin
          total_nxt = SUM_BITS'(cum_r);
          idx_nxt   = '0;
          cum_nxt   = '0;
        end else begin
          cum_nxt = cum_add;
          idx_nxt = idx_r + 1'b1;
        end
      end
      BS_WALK: begin
        if (hit) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = STATUS_CHOSEN;
          out_data_nxt.chosen_slot = SLOT_BITS'(idx_r);
          out_data_nxt.total_rate  = total_r;
        end else if (walk_done) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = STATUS_NONE;
          out_data_nxt.chosen_slot = '0;
          out_data_nxt.total_rate  = total_r;
        end else begin
          cum_nxt = cum_add;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
      rate_sum_r  <= '0;
      occ_r       <= '0;
      for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
        rate_tbl_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rate_sum_r  <= rate_sum_nxt;
      if (tbl_we) begin
        rate_tbl_r[q_head.slot] <= q_head.rate;
      end
      if (occ_we) begin
        occ_r[q_head.slot] <= q_head.occ;
      end
    end
  end

  // The scaling product is split at bit 32 of the total; the high part is narrow.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    total_r    <= total_nxt;
    cum_r      <= cum_nxt;
    idx_r      <= idx_nxt;
    if (q_pop) begin
      free_r <= (q_head.op == OP_FREE);
      frac_r <= q_head.frac;
    end
    if (state_r == BS_MUL) begin
      plo_r <= (2*FRAC_BITS)'(frac_r) * (2*FRAC_BITS)'(total_r[FRAC_BITS-1:0]);
      phi_r <= (FRAC_BITS+HI_BITS)'(frac_r) *
               (FRAC_BITS+HI_BITS)'(total_r[SUM_BITS-1:FRAC_BITS]);
    end
    if (state_r == BS_ADD) begin
      target_r <= SUM_BITS'(phi_r + (FRAC_BITS+HI_BITS)'(plo_r[2*FRAC_BITS-1:FRAC_BITS]));
    end
  end

`ifndef ASSERT_OFF
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_WALK || state_r == BS_SUM) |-> (idx_r <= walk_len))
    else $error("walk position ran past the neighbour count");

  a_chosen_walked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STATUS_CHOSEN) |->
      (int'(out_data_r.chosen_slot) < int'(walk_len)))
    else $error("chosen slot lies outside the walked range");

  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && is_update) |=> (out_valid_r && out_data_r.status == STATUS_DONE))
    else $error("update transaction produced no completion result");
`endif

endmodule

// ===== sv/weighted_hop_selector_top.sv =====
// A transaction passes the front hold register and a queue entry; for an update the back end
// then raises registered out_valid, while a pick runs the MUL, ADD and WALK states first, the
// walk reading one stored rate per cycle. A pick over unoccupied slots first sums the walked
// rates in the SUM state. The back end takes queued updates back to back but holds the queue
// while a pick runs. A two-entry queue lets the front take new transactions while a pick is walking.
// Synchronous active-low reset clears the rate table, occupancy, running sum and count.
module weighted_hop_selector_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  whs_pkg::whs_in_t                  in_data,
  output logic                              out_valid,
  output whs_pkg::whs_out_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [whs_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [whs_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [whs_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import whs_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  q_push;
  logic                  q_pop;
  whs_item_t             q_in_item;
  whs_item_t             q_head;
  whs_qstat_t            q_stat;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_NEIGHBOUR_COUNT);
  assign prdata  = reg_sel ? APB_DATA_BITS'(count_r) : '0;

  always_comb begin
    count_nxt = count_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      count_nxt = pwdata[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  whs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  whs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  whs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .neighbour_count (count_r),
    .q_head          (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_data        (out_data)
  );

endmodule
